// ----- src/assert_macros.svh -----
// Assertion macros for the RTL; complex_alu_top includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition: %m");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- src/cxa_pkg.sv -----
// Operation and status codes of the complex ALU.
package cxa_pkg;
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_GT  = 3'd4;
    localparam logic [2:0] OP_LT  = 3'd5;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;
    localparam logic [1:0] ST_NC  = 2'd3;
endpackage

// ----- src/cxa_in_if.sv -----
// Input channel of the complex ALU: operation and two complex operands.
interface cxa_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic [2:0]          operation;
    logic signed [W-1:0] a_real;
    logic signed [W-1:0] a_imag;
    logic signed [W-1:0] b_real;
    logic signed [W-1:0] b_imag;

    modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
    modport sink (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ----- src/cxa_out_if.sv -----
// Output channel of the complex ALU: result and status.
interface cxa_out_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] res_real;
    logic signed [W-1:0] res_imag;
    logic                compare_true;
    logic [1:0]          status;

    modport source (output valid, res_real, res_imag, compare_true, status, input ready);
    modport sink (input valid, res_real, res_imag, compare_true, status, output ready);
endinterface

// ----- src/cxa_mult.sv -----
// Two-stage product unit: partial products, then the sums used by multiply and divide.
module cxa_mult #(
    parameter int W = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   ar,
    input  logic signed [W-1:0]   ai,
    input  logic signed [W-1:0]   br,
    input  logic signed [W-1:0]   bi,
    output logic signed [2*W+1:0] mul_re,
    output logic signed [2*W+1:0] mul_im,
    output logic signed [2*W+1:0] div_re,
    output logic signed [2*W+1:0] div_im,
    output logic [2*W-1:0]        den
);
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;

    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_brr_reg, p_bii_reg;
    logic signed [SW-1:0] mul_re_reg, mul_im_reg, div_re_reg, div_im_reg;
    logic [PW-1:0]        den_reg;
    logic signed [SW-1:0] e_rr, e_ii, e_ir, e_ri;
    logic [PW-1:0]        den_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rr_reg  <= ar * br;
            p_ii_reg  <= ai * bi;
            p_ir_reg  <= ai * br;
            p_ri_reg  <= ar * bi;
            p_brr_reg <= br * br;
            p_bii_reg <= bi * bi;
        end
    end

    assign e_rr = {{2{p_rr_reg[PW-1]}}, p_rr_reg};
    assign e_ii = {{2{p_ii_reg[PW-1]}}, p_ii_reg};
    assign e_ir = {{2{p_ir_reg[PW-1]}}, p_ir_reg};
    assign e_ri = {{2{p_ri_reg[PW-1]}}, p_ri_reg};
    // Both squares are nonnegative and their sum is at most 2^(2W-1), so it fits unsigned.
    assign den_next = $unsigned(p_brr_reg) + $unsigned(p_bii_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_re_reg <= e_rr - e_ii;
            mul_im_reg <= e_ir + e_ri;
            div_re_reg <= e_rr + e_ii;
            div_im_reg <= e_ir - e_ri;
            den_reg    <= den_next;
        end
    end

    assign mul_re = mul_re_reg;
    assign mul_im = mul_im_reg;
    assign div_re = div_re_reg;
    assign div_im = div_im_reg;
    assign den    = den_reg;
endmodule

// ----- src/cxa_div_stage.sv -----
// One restoring division step: produces one quotient bit.
module cxa_div_stage #(
    parameter int RW  = 58,
    parameter int QW  = 17,
    parameter int DW  = 32,
    parameter int BIT = 0
) (
    input  logic [RW-1:0] rem_in,
    input  logic [QW-1:0] quo_in,
    input  logic [DW-1:0] den,
    output logic [RW-1:0] rem_out,
    output logic [QW-1:0] quo_out
);
    logic [RW-1:0] den_sh;

    assign den_sh = RW'(den) << BIT;

    always_comb
    begin
        rem_out = rem_in;
        quo_out = quo_in;
        if (rem_in >= den_sh)
        begin
            rem_out      = rem_in - den_sh;
            quo_out[BIT] = 1'b1;
        end
    end
endmodule

// ----- src/complex_alu_top.sv -----
// Pipeline: DATA_WIDTH + 6 register stages from the input register to the result register (22 by default).
// Throughput: one word per cycle while the output is not stalled; the divider is one restoring step per stage.
// The whole pipeline advances together whenever the output register is free or taken.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data is not reset.
// Stages: input register, products, sums, finish/divide setup, divide steps, output.
module complex_alu_top import cxa_pkg::*; #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input logic       clk,
    input logic       rst_n,
    cxa_in_if.sink    in_ch,
    cxa_out_if.source out_ch
);
`include "assert_macros.svh"

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2 * W + 2;
    localparam int DW = 2 * W;
    localparam int RW = 3 * W + F + 2;
    localparam int QW = W + 1;
    localparam int NS = W + 1;

    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]          op;
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic                cmp;
        logic [1:0]          st;
        logic                dz;
        logic                neg_re;
        logic                neg_im;
        logic                ovf_re;
        logic                ovf_im;
    } side_t;

    function automatic logic signed [SW-1:0] sx(input logic signed [W-1:0] v);
        return {{(SW-W){v[W-1]}}, v};
    endfunction

    // Returns the saturation flag on top of the clipped value.
    function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] x);
        if (x > MAXV)
            return {1'b1, MAXV[W-1:0]};
        else if (x < MINV)
            return {1'b1, MINV[W-1:0]};
        else
            return {1'b0, x[W-1:0]};
    endfunction

    // Signs and clips a quotient magnitude.
    function automatic logic [W:0] div_fin(input logic [QW-1:0] q, input logic neg,
                                           input logic ovf);
        logic big;
        if (neg)
        begin
            big = ovf || q[W] || (q[W-1] && (|q[W-2:0]));
            if (big)
                return {1'b1, MINV[W-1:0]};
            else
                return {1'b0, W'(-q[W-1:0])};
        end
        else
        begin
            big = ovf || q[W] || q[W-1];
            if (big)
                return {1'b1, MAXV[W-1:0]};
            else
                return {1'b0, q[W-1:0]};
        end
    endfunction

    logic en;

    // Stage 1: input register.
    logic                s1_vld_reg;
    logic [2:0]          s1_op_reg;
    logic signed [W-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // Stages 2 and 3: simple results travel beside the product unit.
    logic  s2_vld_reg, s3_vld_reg;
    side_t s2_side_reg, s3_side_reg, s2_side_next, s4_side_next;

    logic signed [SW-1:0] mul_re, mul_im, div_re, div_im;
    logic [DW-1:0]        den;

    // Divide chain; index 0 is loaded by stage 4.
    logic          vld_reg [0:NS];
    side_t         side_reg [0:NS];
    logic [QW-1:0] qre_reg [0:NS];
    logic [QW-1:0] qim_reg [0:NS];
    logic [RW-1:0] rre_reg [0:NS-1];
    logic [RW-1:0] rim_reg [0:NS-1];
    logic [DW-1:0] den_reg [0:NS-1];
    logic [QW-1:0] qre_next [0:NS-1];
    logic [QW-1:0] qim_next [0:NS-1];

    logic [RW-1:0] nre_next, nim_next;

    // Output register.
    logic                out_vld_reg;
    logic signed [W-1:0] out_re_reg, out_im_reg, out_re_next, out_im_next;
    logic                out_cmp_reg, out_cmp_next;
    logic [1:0]          out_st_reg, out_st_next;

    assign en          = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_ch.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg   <= in_ch.operation;
            s1_ar_reg   <= in_ch.a_real;
            s1_ai_reg   <= in_ch.a_imag;
            s1_br_reg   <= in_ch.b_real;
            s1_bi_reg   <= in_ch.b_imag;
            s2_side_reg <= s2_side_next;
            s3_side_reg <= s2_side_reg;
        end
    end

    always_comb
    begin
        logic [W:0] t, u;
        s2_side_next    = '0;
        s2_side_next.op = s1_op_reg;
        t               = '0;
        u               = '0;
        case (s1_op_reg)
            OP_ADD, OP_SUB:
            begin
                if (s1_op_reg == OP_ADD)
                begin
                    t = sat_fn(sx(s1_ar_reg) + sx(s1_br_reg));
                    u = sat_fn(sx(s1_ai_reg) + sx(s1_bi_reg));
                end
                else
                begin
                    t = sat_fn(sx(s1_ar_reg) - sx(s1_br_reg));
                    u = sat_fn(sx(s1_ai_reg) - sx(s1_bi_reg));
                end
                s2_side_next.re = t[W-1:0];
                s2_side_next.im = u[W-1:0];
                s2_side_next.st = (t[W] || u[W]) ? ST_SAT : ST_OK;
            end
            OP_GT, OP_LT:
            begin
                if (s1_ai_reg != '0 || s1_bi_reg != '0)
                    s2_side_next.st = ST_NC;
                else if (s1_op_reg == OP_GT)
                    s2_side_next.cmp = s1_ar_reg > s1_br_reg;
                else
                    s2_side_next.cmp = s1_ar_reg < s1_br_reg;
            end
            default:
            begin
                s2_side_next.st = ST_OK;
            end
        endcase
    end

    cxa_mult #(.W(W)) u_mult (
        .clk    (clk),
        .en     (en),
        .ar     (s1_ar_reg),
        .ai     (s1_ai_reg),
        .br     (s1_br_reg),
        .bi     (s1_bi_reg),
        .mul_re (mul_re),
        .mul_im (mul_im),
        .div_re (div_re),
        .div_im (div_im),
        .den    (den)
    );

    // Stage 4: finish multiply (floor shift, clip) and set up the divide.
    always_comb
    begin
        logic [W:0]    m, n;
        logic [SW-1:0] mag_re, mag_im;
        logic [RW-1:0] lim;
        s4_side_next = s3_side_reg;
        m            = sat_fn(mul_re >>> F);
        n            = sat_fn(mul_im >>> F);
        if (s3_side_reg.op == OP_MUL)
        begin
            s4_side_next.re = m[W-1:0];
            s4_side_next.im = n[W-1:0];
            s4_side_next.st = (m[W] || n[W]) ? ST_SAT : ST_OK;
        end
        s4_side_next.neg_re = div_re[SW-1];
        s4_side_next.neg_im = div_im[SW-1];
        mag_re              = div_re[SW-1] ? $unsigned(-div_re) : $unsigned(div_re);
        mag_im              = div_im[SW-1] ? $unsigned(-div_im) : $unsigned(div_im);
        nre_next            = RW'(mag_re) << F;
        nim_next            = RW'(mag_im) << F;
        lim                 = RW'(den) << (W + 1);
        // A quotient that needs more than W+1 bits is clipped no matter what.
        s4_side_next.ovf_re = nre_next >= lim;
        s4_side_next.ovf_im = nim_next >= lim;
        s4_side_next.dz     = den == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s4_side_next;
            rre_reg[0]  <= nre_next;
            rim_reg[0]  <= nim_next;
            qre_reg[0]  <= '0;
            qim_reg[0]  <= '0;
            den_reg[0]  <= den;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                qre_reg[k+1]  <= qre_next[k];
                qim_reg[k+1]  <= qim_next[k];
            end
        end

        if (k < NS - 1)
        begin : g_mid
            logic [RW-1:0] rre_next, rim_next;

            cxa_div_stage #(.RW(RW), .QW(QW), .DW(DW), .BIT(W - k)) u_re (
                .rem_in  (rre_reg[k]),
                .quo_in  (qre_reg[k]),
                .den     (den_reg[k]),
                .rem_out (rre_next),
                .quo_out (qre_next[k])
            );
            cxa_div_stage #(.RW(RW), .QW(QW), .DW(DW), .BIT(W - k)) u_im (
                .rem_in  (rim_reg[k]),
                .quo_in  (qim_reg[k]),
                .den     (den_reg[k]),
                .rem_out (rim_next),
                .quo_out (qim_next[k])
            );

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rre_reg[k+1] <= rre_next;
                    rim_reg[k+1] <= rim_next;
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
        else
        begin : g_last
            cxa_div_stage #(.RW(RW), .QW(QW), .DW(DW), .BIT(W - k)) u_re (
                .rem_in  (rre_reg[k]),
                .quo_in  (qre_reg[k]),
                .den     (den_reg[k]),
                .rem_out (),
                .quo_out (qre_next[k])
            );
            cxa_div_stage #(.RW(RW), .QW(QW), .DW(DW), .BIT(W - k)) u_im (
                .rem_in  (rim_reg[k]),
                .quo_in  (qim_reg[k]),
                .den     (den_reg[k]),
                .rem_out (),
                .quo_out (qim_next[k])
            );
        end
    end

    // Output stage: sign and clip the quotients, pick the result.
    always_comb
    begin
        side_t      s;
        logic [W:0] dr, di;
        s            = side_reg[NS];
        dr           = div_fin(qre_reg[NS], s.neg_re, s.ovf_re);
        di           = div_fin(qim_reg[NS], s.neg_im, s.ovf_im);
        out_re_next  = s.re;
        out_im_next  = s.im;
        out_cmp_next = s.cmp;
        out_st_next  = s.st;
        if (s.op == OP_DIV)
        begin
            out_cmp_next = 1'b0;
            if (s.dz)
            begin
                out_re_next = '0;
                out_im_next = '0;
                out_st_next = ST_DZ;
            end
            else
            begin
                out_re_next = dr[W-1:0];
                out_im_next = di[W-1:0];
                out_st_next = (dr[W] || di[W]) ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg  <= out_re_next;
            out_im_reg  <= out_im_next;
            out_cmp_reg <= out_cmp_next;
            out_st_reg  <= out_st_next;
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.res_real     = out_re_reg;
    assign out_ch.res_imag     = out_im_reg;
    assign out_ch.compare_true = out_cmp_reg;
    assign out_ch.status       = out_st_reg;

    `ASSERT_CLK(a_s1_adv, s1_vld_reg && en |=> s2_vld_reg)
    `ASSERT_CLK(a_dz_zero, out_ch.valid && out_ch.status == ST_DZ |-> out_ch.res_real == '0 && out_ch.res_imag == '0)
    `ASSERT_NEVER(a_cmp_status, out_ch.valid && out_ch.compare_true && out_ch.status != ST_OK)
    `ASSERT_CLK(a_nc_zero, out_ch.valid && out_ch.status == ST_NC |-> out_ch.res_real == '0 && !out_ch.compare_true)
endmodule
